// ===== hw/rtl/cmpq_pkg.sv =====
// types, constants and command codes for the coin meter pulse queue
package cmpq_pkg;

    localparam int CHANNELS  = 4;
    localparam int COUNT_W   = 16;
    localparam int AMOUNT_W  = 16;
    localparam int METER_W   = 4;
    localparam int SUM_W     = ((COUNT_W > AMOUNT_W) ? COUNT_W : AMOUNT_W) + 1;

    localparam logic [1:0] PHASE_ON  = 2'd2;
    localparam logic [1:0] PHASE_OFF = 2'd1;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_ADD   = 3'd1,
        CMD_CLEAR = 3'd2,
        CMD_OPEN  = 3'd3,
        CMD_CLOSE = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [2:0]          cmd;
        logic [1:0]          channel;
        logic [AMOUNT_W-1:0] amount;
    } req_beat_t;

    typedef struct packed {
        logic [METER_W-1:0] meters;
        logic               status;
    } rsp_beat_t;

    // per-channel control for one processed beat
    typedef struct packed {
        logic                step;
        logic                tick;
        logic                clear;
        logic                add;
        logic [AMOUNT_W-1:0] amount;
    } chan_ctl_t;

endpackage

// ===== hw/rtl/coin_meter_pulse_queue.sv =====
// top level: command register, channel array and response register
// Takes one command beat per cycle while rsp_stall stays low. A beat sits in the
// command register, where the open/close flags and all channels update in parallel,
// and its response (latched meter bits after the command, and a refused flag)
// is registered into the response register when the beat advances. Ticks run a
// three-tick on/off/idle cycle per channel with pending pulses; add and clear
// are refused until the block is open. Meter bits above bit 3 are not shown.
module coin_meter_pulse_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  cmpq_pkg::req_beat_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output cmpq_pkg::rsp_beat_t rsp
);
    import cmpq_pkg::*;

    logic          cmd_valid_reg;
    req_beat_t     cmd_reg;
    logic          advance;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_beat_t     rsp_reg, rsp_next;
    logic          init_reg, init_next;
    logic          open_reg, open_next;
    logic          status;
    logic          do_tick, do_clear, do_add;
    logic [CHANNELS-1:0] meter_next;
    chan_ctl_t     ctl [CHANNELS];

    // command register moves on when the response slot is free or draining
    assign advance   = cmd_valid_reg && !(rsp_valid_reg && rsp_stall);
    assign req_stall = cmd_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else if (!req_stall)
            cmd_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
            cmd_reg <= req;
    end

    always_comb
    begin
        init_next = init_reg;
        open_next = open_reg;
        status    = 1'b0;
        do_tick   = 1'b0;
        do_clear  = 1'b0;
        do_add    = 1'b0;
        case (cmd_reg.cmd)
            CMD_TICK:
                do_tick = init_reg;
            CMD_OPEN:
            begin
                do_clear  = 1'b1;
                init_next = 1'b1;
                open_next = 1'b1;
            end
            CMD_CLOSE:
                open_next = 1'b0;
            CMD_ADD:
            begin
                if (!init_reg || !open_reg || 32'(cmd_reg.channel) >= CHANNELS)
                    status = 1'b1;
                else
                    do_add = 1'b1;
            end
            CMD_CLEAR:
            begin
                if (!init_reg || !open_reg)
                    status = 1'b1;
                else
                    do_clear = 1'b1;
            end
            default:
                status = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= 1'b0;
            open_reg <= 1'b0;
        end
        else if (advance)
        begin
            init_reg <= init_next;
            open_reg <= open_next;
        end
    end

    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_chan
        always_comb
        begin
            ctl[i].step   = advance;
            ctl[i].tick   = do_tick;
            ctl[i].clear  = do_clear;
            ctl[i].add    = do_add && (32'(cmd_reg.channel) == i);
            ctl[i].amount = cmd_reg.amount;
        end

        cmpq_chan u_chan (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl[i]),
            .meter_next (meter_next[i])
        );
    end

    for (genvar j = 0; j < METER_W; j++)
    begin : g_meter
        if (j < CHANNELS)
        begin : g_used
            assign rsp_next.meters[j] = meter_next[j];
        end
        else
        begin : g_pad
            assign rsp_next.meters[j] = 1'b0;
        end
    end

    assign rsp_next.status = status;

    always_comb
    begin
        if (advance)
            rsp_valid_next = 1'b1;
        else if (rsp_stall)
            rsp_valid_next = rsp_valid_reg;
        else
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== hw/rtl/cmpq_chan.sv =====
// one meter channel: pending count, pulse phase and drive bit
module cmpq_chan (
    input  logic              clk,
    input  logic              rst_n,
    input  cmpq_pkg::chan_ctl_t ctl,
    output logic              meter_next
);
    import cmpq_pkg::*;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [1:0]         phase_reg, phase_next;
    logic               active_reg, active_next;
    logic               meter_reg;
    logic [SUM_W-1:0]   sum;
    logic [1:0]         phase_eff;

    always_comb
    begin
        count_next  = count_reg;
        phase_next  = phase_reg;
        active_next = active_reg;
        meter_next  = meter_reg;
        sum         = SUM_W'(count_reg) + SUM_W'(ctl.amount);
        // an idle channel starts its cycle at the turn-on phase
        phase_eff   = active_reg ? phase_reg : PHASE_ON;
        if (ctl.clear)
        begin
            count_next  = '0;
            phase_next  = '0;
            active_next = 1'b0;
            meter_next  = 1'b0;
        end
        else if (ctl.add)
        begin
            if (sum > SUM_W'({COUNT_W{1'b1}}))
                count_next = '1;
            else
                count_next = sum[COUNT_W-1:0];
        end
        else if (ctl.tick && count_reg != '0)
        begin
            case (phase_eff)
                PHASE_ON:
                begin
                    meter_next  = 1'b1;
                    phase_next  = PHASE_OFF;
                    active_next = 1'b1;
                end
                PHASE_OFF:
                begin
                    meter_next  = 1'b0;
                    phase_next  = 2'd0;
                    active_next = 1'b1;
                end
                default:
                begin
                    active_next = 1'b0;
                    count_next  = count_reg - COUNT_W'(1);
                    phase_next  = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            phase_reg  <= '0;
            active_reg <= 1'b0;
            meter_reg  <= 1'b0;
        end
        else if (ctl.step)
        begin
            count_reg  <= count_next;
            phase_reg  <= phase_next;
            active_reg <= active_next;
            meter_reg  <= meter_next;
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// testbench for the coin meter pulse queue: directed and random command beats
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cmpq_pkg::*;

    localparam int ITEM_TARGET = 1650;
    localparam int PRINT_CAP   = 40;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_beat_t req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_beat_t rsp;

    // predicted meter state
    logic [COUNT_W-1:0] pulses_left [CHANNELS];
    logic [1:0]         pulse_phase [CHANNELS];
    logic               in_cycle [CHANNELS];
    logic [CHANNELS-1:0] meter_bits;
    logic               meters_initd;
    logic               meters_open;

    rsp_beat_t meter_rsp_q [$];
    int        mismatches = 0;
    int        burst_left = 0;
    int        stall_mode = 0;
    int        stall_mode_left = 0;
    int        stall_phase = 0;

    coin_meter_pulse_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #4ms;
        $display("simulation failed");
        $finish;
    end

    function automatic void clear_meters();
        for (int i = 0; i < CHANNELS; i++)
        begin
            pulses_left[i] = '0;
            pulse_phase[i] = '0;
            in_cycle[i]    = 1'b0;
        end
        meter_bits = '0;
    endfunction

    function automatic void tick_meters();
        if (!meters_initd)
            return;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (pulses_left[i] != '0)
            begin
                if (!in_cycle[i])
                begin
                    pulse_phase[i] = PHASE_ON;
                    in_cycle[i]    = 1'b1;
                end
                if (pulse_phase[i] == PHASE_ON)
                begin
                    meter_bits[i]  = 1'b1;
                    pulse_phase[i] = PHASE_OFF;
                end
                else if (pulse_phase[i] == PHASE_OFF)
                begin
                    meter_bits[i]  = 1'b0;
                    pulse_phase[i] = '0;
                end
                else
                begin
                    // idle tick closes the cycle and uses up one pulse
                    in_cycle[i]    = 1'b0;
                    pulses_left[i] = pulses_left[i] - 1'b1;
                    pulse_phase[i] = '0;
                end
            end
        end
    endfunction

    function automatic rsp_beat_t apply_meter_cmd(req_beat_t b);
        rsp_beat_t        r;
        logic [SUM_W-1:0] sum;
        logic             refused;
        refused = 1'b0;
        case (cmd_t'(b.cmd))
            CMD_TICK:
                tick_meters();
            CMD_OPEN:
            begin
                clear_meters();
                meters_initd = 1'b1;
                meters_open  = 1'b1;
            end
            CMD_CLOSE:
                meters_open = 1'b0;
            CMD_ADD:
            begin
                if (!meters_initd || !meters_open || int'(b.channel) >= CHANNELS)
                    refused = 1'b1;
                else
                begin
                    sum = SUM_W'(pulses_left[b.channel]) + SUM_W'(b.amount);
                    pulses_left[b.channel] = (sum > SUM_W'(COUNT_MAX)) ?
                        COUNT_MAX : sum[COUNT_W-1:0];
                end
            end
            CMD_CLEAR:
            begin
                if (!meters_initd || !meters_open)
                    refused = 1'b1;
                else
                    clear_meters();
            end
            default:
                refused = 1'b1;
        endcase
        r.meters     = meter_bits[METER_W-1:0];
        r.status     = refused;
        return r;
    endfunction

    function automatic req_beat_t make_beat(logic [2:0] cmd, logic [1:0] ch,
                                            logic [AMOUNT_W-1:0] amt);
        req_beat_t b;
        b.cmd     = cmd;
        b.channel = ch;
        b.amount  = amt;
        return b;
    endfunction

    function automatic logic [2:0] bad_cmd();
        return 3'(CMD_CLOSE) + 3'($urandom_range(1, 3));
    endfunction

    task automatic report_mismatch(string what, int expv, int gotv);
        if (mismatches < PRINT_CAP)
            $display("%0t: %s expected %0h got %0h", $realtime, what, expv, gotv);
        mismatches++;
    endtask

    // one beat, with random gaps between bursts
    task automatic send_beat(req_beat_t b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req       <= b;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        meter_rsp_q.push_back(apply_meter_cmd(b));
    endtask

    always @(posedge clk)
    begin
        rsp_beat_t want;
        if (rsp_valid && !rsp_stall)
        begin
            if (meter_rsp_q.size() == 0)
                report_mismatch("response with none pending", 0, rsp);
            else
            begin
                want = meter_rsp_q.pop_front();
                if (rsp.meters !== want.meters)
                    report_mismatch("meters", want.meters, rsp.meters);
                if (rsp.status !== want.status)
                    report_mismatch("status", want.status, rsp.status);
            end
        end
    end

    // receiver stall pattern: a random mode, chosen anew when its countdown runs out
    always @(posedge clk)
    begin
        if (stall_mode_left == 0)
        begin
            stall_mode      <= $urandom_range(0, 3);
            stall_mode_left <= $urandom_range(40, 300);
        end
        else
            stall_mode_left <= stall_mode_left - 1;
        stall_phase <= (stall_phase + 1) % 3;
        case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 9) < 6);
            default: rsp_stall <= (stall_phase == 0);
        endcase
    end

    task automatic test_before_open();
        send_beat(make_beat(CMD_TICK, 2'd0, 16'h0000));
        send_beat(make_beat(CMD_ADD, 2'd3, 16'hffff));
        send_beat(make_beat(CMD_CLEAR, 2'd1, 16'h1234));
        send_beat(make_beat(bad_cmd(), 2'd2, 16'haaaa));
        send_beat(make_beat(bad_cmd(), 2'd1, 16'h5555));
        send_beat(make_beat(3'(CMD_CLOSE) + 3'(3), 2'd3, 16'hffff));
        send_beat(make_beat(CMD_CLOSE, 2'd0, 16'h0000));
        send_beat(make_beat(CMD_TICK, 2'd3, 16'hffff));
    endtask

    task automatic test_single_pulse();
        send_beat(make_beat(CMD_OPEN, 2'd0, 16'h0000));
        send_beat(make_beat(CMD_ADD, 2'd0, 16'h0001));
        send_beat(make_beat(CMD_ADD, 2'd1, 16'h0000));
        repeat (4)
            send_beat(make_beat(CMD_TICK, 2'd0, 16'h0000));
    endtask

    task automatic test_saturation();
        send_beat(make_beat(CMD_ADD, 2'd2, 16'hffff));
        send_beat(make_beat(CMD_ADD, 2'd2, 16'h0001));
        send_beat(make_beat(CMD_TICK, 2'd0, 16'h0000));
        send_beat(make_beat(CMD_CLEAR, 2'd0, 16'h0000));
        send_beat(make_beat(CMD_TICK, 2'd0, 16'h0000));
    endtask

    task automatic test_close_keeps_ticking();
        send_beat(make_beat(CMD_ADD, 2'd3, 16'h0002));
        send_beat(make_beat(CMD_CLOSE, 2'd0, 16'h0000));
        send_beat(make_beat(CMD_ADD, 2'd3, 16'h0001));
        send_beat(make_beat(CMD_TICK, 2'd0, 16'h0000));
    endtask

    task automatic test_random_traffic();
        int          live;
        int          pick;
        logic [2:0]  cmd;
        logic [15:0] amt;
        live = 0;
        send_beat(make_beat(CMD_OPEN, 2'($urandom), 16'($urandom)));
        while (live < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 58)
                cmd = CMD_TICK;
            else if (pick < 86)
                cmd = CMD_ADD;
            else if (pick < 90)
                cmd = CMD_CLEAR;
            else if (pick < 94)
                cmd = CMD_OPEN;
            else if (pick < 97)
                cmd = CMD_CLOSE;
            else
                cmd = bad_cmd();
            // mostly small counts so channels drain back to zero
            pick = $urandom_range(0, 9);
            if (pick < 7)
                amt = 16'($urandom_range(1, 3));
            else if (pick < 9)
                amt = 16'($urandom_range(0, 31));
            else
                amt = 16'($urandom);
            send_beat(make_beat(cmd, 2'($urandom), amt));
            live++;
        end
    endtask

    initial
    begin
        meters_initd = 1'b0;
        meters_open  = 1'b0;
        clear_meters();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_before_open();
        test_single_pulse();
        test_saturation();
        test_close_keeps_ticking();
        test_random_traffic();
        req_valid <= 1'b0;
        while (meter_rsp_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
